// ===== rtl/assert_macros.svh =====
// assertion helpers used by zip_legacy_key_update
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every rising clock edge, off while reset is low
`define ZLKU_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// property checked on every rising clock edge, reset included
`define ZLKU_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

// ===== rtl/zlku_pkg.sv =====
// ----------------------------------------------------------------------------
// zlku_pkg
// Types, constants and byte-step helpers for the legacy zip key register.
// ----------------------------------------------------------------------------
`default_nettype none

package zlku_pkg;

  localparam int unsigned KeyW   = 32;
  localparam int unsigned ByteW  = 8;
  localparam int unsigned CfgIdxW = 2;

  localparam logic [KeyW-1:0] CrcPoly    = 32'hEDB8_8320;
  localparam logic [KeyW-1:0] KeyMultInv = 32'hD94F_A8CD;
  localparam logic [KeyW-1:0] ResetX     = 32'h1234_5678;
  localparam logic [KeyW-1:0] ResetY     = 32'h2345_6789;
  localparam logic [KeyW-1:0] ResetZ     = 32'h3456_7890;

  // configuration register indexes
  localparam logic [CfgIdxW-1:0] CfgInitX = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgInitY = 2'd1;
  localparam logic [CfgIdxW-1:0] CfgInitZ = 2'd2;

  typedef enum logic [1:0] {
    OpRestart  = 2'd0,
    OpAbsorb   = 2'd1,
    OpDecrypt  = 2'd2,
    OpBackward = 2'd3
  } op_e;

  // reflected crc-32, one byte forward
  function automatic logic [KeyW-1:0] crc_step(input logic [KeyW-1:0] v,
                                               input logic [ByteW-1:0] b);
    logic [KeyW-1:0] r;
    r = v ^ {{(KeyW-ByteW){1'b0}}, b};
    for (int i = 0; i < ByteW; i++) begin
      r = r[0] ? ((r >> 1) ^ CrcPoly) : (r >> 1);
    end
    return r;
  endfunction

  // exact inverse of crc_step
  function automatic logic [KeyW-1:0] crc_unstep(input logic [KeyW-1:0] v,
                                                 input logic [ByteW-1:0] b);
    logic [KeyW-1:0] r;
    r = v;
    for (int i = 0; i < ByteW; i++) begin
      r = r[KeyW-1] ? (((r ^ CrcPoly) << 1) | {{(KeyW-1){1'b0}}, 1'b1}) : (r << 1);
    end
    return r ^ {{(KeyW-ByteW){1'b0}}, b};
  endfunction

  // y * 0x08088405 mod 2^32, the constant has six set bits
  function automatic logic [KeyW-1:0] key_mult(input logic [KeyW-1:0] y);
    return (y << 27) + (y << 19) + (y << 15) + (y << 10) + (y << 2) + y;
  endfunction

  // keystream byte, only the low 16 bits of the product matter
  function automatic logic [ByteW-1:0] stream_byte(input logic [KeyW-1:0] z);
    logic [15:0] t;
    logic [15:0] prod;
    t    = z[15:0] | 16'h0002;
    prod = t * (t ^ 16'h0001);
    return prod[15:8];
  endfunction

endpackage

`default_nettype wire

// ===== rtl/zip_legacy_key_update.sv =====
// ----------------------------------------------------------------------------
// zip_legacy_key_update
// Legacy zip cipher key register: restart, absorb, decrypt forward or step
// backward over one byte per item and report the keys after each step.
// ----------------------------------------------------------------------------
// path: input accept goes to the input register, then the key update lands in
//   the result register, which is also the key state
// throughput: one item per cycle while m_axis_tready_i is high, set by the single key update pass per byte
// reset: keys and restart values take 0x12345678 / 0x23456789 / 0x34567890,
//   both stages empty
`default_nettype none

module zip_legacy_key_update (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  // configuration write port
  input  wire logic                          cfg_we_i,
  input  wire logic [zlku_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  wire logic [zlku_pkg::KeyW-1:0]     cfg_data_i,
  // input items
  input  wire logic                          s_axis_tvalid_i,
  output logic                               s_axis_tready_o,
  input  wire logic [7:0]                    s_axis_tdata_i,  // [7:0] data_byte
  input  wire logic [1:0]                    s_axis_tuser_i,  // [1:0] operation
  // result items
  output logic                               m_axis_tvalid_o,
  input  wire logic                          m_axis_tready_i,
  // [31:0] key_x, [63:32] key_y, [95:64] key_z, [103:96] keystream_byte,
  // [111:104] plain_byte
  output logic [111:0]                       m_axis_tdata_o
);

  import zlku_pkg::*;

  logic [KeyW-1:0] init_x_q, init_y_q, init_z_q;

  logic             in_valid_q;
  op_e              in_op_q;
  logic [ByteW-1:0] in_byte_q;

  logic             out_valid_q;
  logic [KeyW-1:0]  key_x_q, key_y_q, key_z_q;
  logic [KeyW-1:0]  key_x_d, key_y_d, key_z_d;
  logic [ByteW-1:0] plain_q, plain_d;

  logic advance;
  logic in_take;

  assign advance         = in_valid_q && (!out_valid_q || m_axis_tready_i);
  assign s_axis_tready_o = !in_valid_q || advance;
  assign in_take         = s_axis_tvalid_i && s_axis_tready_o;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      init_x_q <= ResetX;
      init_y_q <= ResetY;
      init_z_q <= ResetZ;
    end else if (cfg_we_i) begin
      if (cfg_index_i == CfgInitX) init_x_q <= cfg_data_i;
      if (cfg_index_i == CfgInitY) init_y_q <= cfg_data_i;
      if (cfg_index_i == CfgInitZ) init_z_q <= cfg_data_i;
    end
  end

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready_o) begin
      in_valid_q <= s_axis_tvalid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      in_op_q   <= op_e'(s_axis_tuser_i);
      in_byte_q <= s_axis_tdata_i;
    end
  end

  // key update pass
  always_comb begin
    logic [ByteW-1:0] p;
    logic [KeyW-1:0]  x_f, y_f, z_b;
    key_x_d = key_x_q;
    key_y_d = key_y_q;
    key_z_d = key_z_q;
    plain_d = '0;
    p       = in_byte_q;
    x_f     = '0;
    y_f     = '0;
    z_b     = '0;
    unique case (in_op_q)
      OpRestart: begin
        key_x_d = init_x_q;
        key_y_d = init_y_q;
        key_z_d = init_z_q;
      end
      OpAbsorb, OpDecrypt: begin
        if (in_op_q == OpDecrypt) begin
          p       = in_byte_q ^ stream_byte(key_z_q);
          plain_d = p;
        end
        x_f     = crc_step(key_x_q, p);
        y_f     = key_mult(key_y_q + {{(KeyW-ByteW){1'b0}}, x_f[ByteW-1:0]}) + 32'd1;
        key_x_d = x_f;
        key_y_d = y_f;
        key_z_d = crc_step(key_z_q, y_f[KeyW-1 -: ByteW]);
      end
      OpBackward: begin
        z_b     = crc_unstep(key_z_q, key_y_q[KeyW-1 -: ByteW]);
        key_y_d = (key_y_q - 32'd1) * KeyMultInv
                  - {{(KeyW-ByteW){1'b0}}, key_x_q[ByteW-1:0]};
        key_z_d = z_b;
        p       = in_byte_q ^ stream_byte(z_b);
        plain_d = p;
        key_x_d = crc_unstep(key_x_q, p);
      end
      default: ;
    endcase
  end

  // result register, doubles as the key state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      key_x_q     <= ResetX;
      key_y_q     <= ResetY;
      key_z_q     <= ResetZ;
    end else begin
      if (advance) begin
        out_valid_q <= 1'b1;
        key_x_q     <= key_x_d;
        key_y_q     <= key_y_d;
        key_z_q     <= key_z_d;
      end else if (m_axis_tready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      plain_q <= plain_d;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {plain_q, stream_byte(key_z_q), key_z_q, key_y_q, key_x_q};

`include "assert_macros.svh"

  `ZLKU_ASSERT(a_in_held, in_valid_q && !advance |=> in_valid_q, "input item dropped")
  `ZLKU_ASSERT(a_adv_out, advance |=> out_valid_q, "result not presented after update")
  `ZLKU_ASSERT(a_restart, advance && in_op_q == OpRestart |=>
    key_x_q == $past(init_x_q) && key_z_q == $past(init_z_q), "restart did not load keys")
  `ZLKU_ASSERT(a_absorb_plain, advance && in_op_q == OpAbsorb |=>
    plain_q == '0, "absorb gave nonzero plain byte")

endmodule

`default_nettype wire
